// ===== hw/rtl/hbrd_pkg.sv =====
// Shared types and constants for the handheld bus region decoder.
`timescale 1ns / 1ps

package hbrd_pkg;

  typedef enum logic [3:0] {
    T_NONE         = 4'd0,
    T_BIOS         = 4'd1,
    T_BIOS_LATCHED = 4'd2,
    T_EWRAM        = 4'd3,
    T_IWRAM        = 4'd4,
    T_IO           = 4'd5,
    T_PALETTE      = 4'd6,
    T_VRAM         = 4'd7,
    T_OAM          = 4'd8,
    T_CART         = 4'd9,
    T_OPEN         = 4'd10
  } target_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2,
    SZ_WIDE = 2'd3
  } size_t;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [7:0] REG_BIOS    = 8'h00;
  localparam logic [7:0] REG_EWRAM   = 8'h02;
  localparam logic [7:0] REG_IWRAM   = 8'h03;
  localparam logic [7:0] REG_IO      = 8'h04;
  localparam logic [7:0] REG_PALETTE = 8'h05;
  localparam logic [7:0] REG_VRAM    = 8'h06;
  localparam logic [7:0] REG_OAM     = 8'h07;
  localparam logic [7:0] REG_ROM_LO  = 8'h08;
  localparam logic [7:0] REG_ROM_HI  = 8'h0D;
  localparam logic [7:0] REG_SRAM_LO = 8'h0E;
  localparam logic [7:0] REG_SRAM_HI = 8'h0F;

  localparam logic [23:0] IO_SPAN    = 24'h000400;
  localparam int          VRAM_BITS  = 17;
  localparam logic [16:0] VRAM_FOLD  = 17'h08000;
  localparam int          QUEUE_DEPTH = 2;

  // Classified access as it travels from the front to the back.
  typedef struct packed {
    target_t     target;
    logic        action;
    size_t       size;
    logic        dup;
    logic [27:0] addr;
    logic [31:0] wdata;
  } item_t;

endpackage

// ===== hw/rtl/hbrd_if.sv =====
// Handshake channel interfaces for bus accesses and routing results.
`timescale 1ns / 1ps

interface hbrd_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  access_size;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [31:0] cpu_pc;

  modport source (output valid, action, access_size, address, write_data, cpu_pc,
                  input ready);
  modport sink (input valid, action, access_size, address, write_data, cpu_pc,
                output ready);
endinterface

interface hbrd_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  target;
  logic [27:0] region_offset;
  logic [3:0]  byte_enable;
  logic [31:0] lane_data;
  logic        refresh_bios_latch;

  modport source (output valid, target, region_offset, byte_enable, lane_data,
                  refresh_bios_latch, input ready);
  modport sink (input valid, target, region_offset, byte_enable, lane_data,
                refresh_bios_latch, output ready);
endinterface

// ===== hw/rtl/hbrd_front.sv =====
// Front end: accepts bus accesses, aligns them and picks the target region.
`timescale 1ns / 1ps

module hbrd_front #(
  parameter int BIOS_BYTES = 16384
) (
  hbrd_req_if.sink     req,
  input  logic         q_ready,
  output logic         push,
  output hbrd_pkg::item_t push_item
);

  localparam logic [31:0] BIOS_LIM = 32'(BIOS_BYTES);
  localparam logic [31:0] PC_LIM   = 32'(BIOS_BYTES + 8);

  hbrd_pkg::size_t   sz;
  hbrd_pkg::target_t tgt;
  logic [31:0]       addr;
  logic [7:0]        region;
  logic              act;

  assign req.ready = q_ready;
  assign push      = req.valid && q_ready;

  always_comb begin
    act = req.action;
    sz  = hbrd_pkg::size_t'(req.access_size);
    if (sz == hbrd_pkg::SZ_WIDE) begin
      sz = hbrd_pkg::SZ_WORD;
    end
    case (sz)
      hbrd_pkg::SZ_BYTE: addr = req.address;
      hbrd_pkg::SZ_HALF: addr = {req.address[31:1], 1'b0};
      default:           addr = {req.address[31:2], 2'b00};
    endcase
    region = addr[31:24];
    tgt    = hbrd_pkg::T_NONE;

    case (region)
      hbrd_pkg::REG_BIOS: begin
        if (act == hbrd_pkg::ACT_READ && addr < BIOS_LIM) begin
          tgt = (req.cpu_pc >= PC_LIM) ? hbrd_pkg::T_BIOS_LATCHED : hbrd_pkg::T_BIOS;
        end
      end
      hbrd_pkg::REG_EWRAM:   tgt = hbrd_pkg::T_EWRAM;
      hbrd_pkg::REG_IWRAM:   tgt = hbrd_pkg::T_IWRAM;
      hbrd_pkg::REG_IO: begin
        if (addr[23:0] < hbrd_pkg::IO_SPAN) begin
          tgt = hbrd_pkg::T_IO;
        end
      end
      hbrd_pkg::REG_PALETTE: tgt = hbrd_pkg::T_PALETTE;
      hbrd_pkg::REG_VRAM:    tgt = hbrd_pkg::T_VRAM;
      hbrd_pkg::REG_OAM: begin
        // Object RAM ignores byte writes.
        if (!(act == hbrd_pkg::ACT_WRITE && sz == hbrd_pkg::SZ_BYTE)) begin
          tgt = hbrd_pkg::T_OAM;
        end
      end
      hbrd_pkg::REG_SRAM_LO, hbrd_pkg::REG_SRAM_HI: tgt = hbrd_pkg::T_CART;
      default: begin
        if (region >= hbrd_pkg::REG_ROM_LO && region <= hbrd_pkg::REG_ROM_HI) begin
          if (act == hbrd_pkg::ACT_READ) begin
            tgt = hbrd_pkg::T_CART;
          end
        end else if (act == hbrd_pkg::ACT_READ) begin
          tgt = hbrd_pkg::T_OPEN;
        end
      end
    endcase

    push_item.target = tgt;
    push_item.action = act;
    push_item.size   = sz;
    push_item.dup    = (tgt == hbrd_pkg::T_PALETTE || tgt == hbrd_pkg::T_VRAM) &&
                       act == hbrd_pkg::ACT_WRITE && sz == hbrd_pkg::SZ_BYTE;
    push_item.addr   = addr[27:0];
    push_item.wdata  = req.write_data;
  end

endmodule

// ===== hw/rtl/hbrd_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module hbrd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hbrd_pkg::item_t push_item,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output hbrd_pkg::item_t head
);

  localparam int PTR_W = (hbrd_pkg::QUEUE_DEPTH > 1) ? $clog2(hbrd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(hbrd_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(hbrd_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(hbrd_pkg::QUEUE_DEPTH - 1);

  hbrd_pkg::item_t entries [hbrd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;

  assign ready = (count != DEPTH_C);
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/hbrd_back.sv =====
// Back end: forms offset, lanes and lane data, and holds the result register.
`timescale 1ns / 1ps

module hbrd_back #(
  parameter int EWRAM_BYTES      = 262144,
  parameter int IWRAM_BYTES      = 32768,
  parameter int PALETTE_BYTES    = 1024,
  parameter int VIDEO_RAM_BYTES  = 98304,
  parameter int OBJECT_RAM_BYTES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  hbrd_pkg::item_t q_item,
  output logic            pop,
  hbrd_rsp_if.source      rsp
);

  localparam logic [27:0] EWRAM_MASK   = 28'(EWRAM_BYTES - 1);
  localparam logic [27:0] IWRAM_MASK   = 28'(IWRAM_BYTES - 1);
  localparam logic [27:0] PALETTE_MASK = 28'(PALETTE_BYTES - 1);
  localparam logic [27:0] OAM_MASK     = 28'(OBJECT_RAM_BYTES - 1);
  localparam logic [hbrd_pkg::VRAM_BITS:0] VRAM_LIM = (hbrd_pkg::VRAM_BITS + 1)'(VIDEO_RAM_BYTES);

  logic                          out_valid;
  logic [3:0]                    target;
  logic [27:0]                   region_offset;
  logic [3:0]                    byte_enable;
  logic [31:0]                   lane_data;
  logic                          refresh;

  logic [27:0]                   off;
  logic [3:0]                    be;
  logic [31:0]                   ld;
  logic [hbrd_pkg::VRAM_BITS-1:0] vofs;

  assign pop = q_valid && (!out_valid || rsp.ready);

  always_comb begin
    vofs = q_item.addr[hbrd_pkg::VRAM_BITS-1:0];
    // The video RAM window repeats its upper 32KB bank.
    if ({1'b0, vofs} >= VRAM_LIM) begin
      vofs = vofs - hbrd_pkg::VRAM_FOLD;
    end

    case (q_item.target)
      hbrd_pkg::T_BIOS, hbrd_pkg::T_BIOS_LATCHED, hbrd_pkg::T_CART: off = q_item.addr;
      hbrd_pkg::T_EWRAM:   off = q_item.addr & EWRAM_MASK;
      hbrd_pkg::T_IWRAM:   off = q_item.addr & IWRAM_MASK;
      hbrd_pkg::T_IO:      off = {4'b0, q_item.addr[23:0]};
      hbrd_pkg::T_PALETTE: off = q_item.addr & PALETTE_MASK;
      hbrd_pkg::T_VRAM:    off = 28'(vofs);
      hbrd_pkg::T_OAM:     off = q_item.addr & OAM_MASK;
      default:             off = '0;
    endcase

    case (q_item.size)
      hbrd_pkg::SZ_BYTE: begin
        be = 4'b0001 << q_item.addr[1:0];
        ld = 32'(q_item.wdata[7:0]) << {q_item.addr[1:0], 3'b000};
      end
      hbrd_pkg::SZ_HALF: begin
        be = q_item.addr[1] ? 4'b1100 : 4'b0011;
        ld = 32'(q_item.wdata[15:0]) << {q_item.addr[1], 4'b0000};
      end
      default: begin
        be = 4'b1111;
        ld = q_item.wdata;
      end
    endcase

    if (q_item.action == hbrd_pkg::ACT_READ) begin
      ld = '0;
    end

    // Byte writes to palette and video RAM land on the whole halfword.
    if (q_item.dup) begin
      off[0] = 1'b0;
      be     = q_item.addr[1] ? 4'b1100 : 4'b0011;
      ld     = 32'({q_item.wdata[7:0], q_item.wdata[7:0]}) << {q_item.addr[1], 4'b0000};
    end

    if (q_item.target == hbrd_pkg::T_NONE) begin
      be = '0;
      ld = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      target        <= q_item.target;
      region_offset <= off;
      byte_enable   <= be;
      lane_data     <= ld;
      refresh       <= (q_item.target == hbrd_pkg::T_BIOS);
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.target             = target;
  assign rsp.region_offset      = region_offset;
  assign rsp.byte_enable        = byte_enable;
  assign rsp.lane_data          = lane_data;
  assign rsp.refresh_bios_latch = refresh;

endmodule

// ===== hw/rtl/handheld_bus_region_decoder.sv =====
// Top level of the handheld bus region decoder.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------------
//   req     | in  | action, access_size, address, write_data, cpu_pc
//   rsp     | out | target, region_offset, byte_enable, lane_data,
//           |     | refresh_bios_latch
//
// One item per cycle is sustained while rsp is ready; an accepted item passes
// through the queue and then the result register before it reaches rsp.
// The two-entry queue lets req keep accepting while a result waits on rsp.
// Reset (rst, synchronous) empties the queue and the result register.
// When rsp stalls, req stops only once the queue is full.
`timescale 1ns / 1ps

module handheld_bus_region_decoder #(
  parameter int BIOS_BYTES       = 16384,
  parameter int EWRAM_BYTES      = 262144,
  parameter int IWRAM_BYTES      = 32768,
  parameter int PALETTE_BYTES    = 1024,
  parameter int VIDEO_RAM_BYTES  = 98304,
  parameter int OBJECT_RAM_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  hbrd_req_if.sink    req,
  hbrd_rsp_if.source  rsp
);

  logic            push;
  logic            q_ready;
  logic            q_valid;
  logic            pop;
  hbrd_pkg::item_t push_item;
  hbrd_pkg::item_t q_item;

  hbrd_front #(
    .BIOS_BYTES (BIOS_BYTES)
  ) u_front (
    .req       (req),
    .q_ready   (q_ready),
    .push      (push),
    .push_item (push_item)
  );

  hbrd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .ready     (q_ready),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_item)
  );

  hbrd_back #(
    .EWRAM_BYTES      (EWRAM_BYTES),
    .IWRAM_BYTES      (IWRAM_BYTES),
    .PALETTE_BYTES    (PALETTE_BYTES),
    .VIDEO_RAM_BYTES  (VIDEO_RAM_BYTES),
    .OBJECT_RAM_BYTES (OBJECT_RAM_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

// ===== hw/rtl/hbrd_checker.sv =====
// Port-level checks for the bus region decoder and their binding.
`timescale 1ns / 1ps

module hbrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [3:0]  rsp_target,
  input logic [27:0] rsp_offset,
  input logic [3:0]  rsp_be,
  input logic [31:0] rsp_data,
  input logic        rsp_refresh
);

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target) &&
      $stable(rsp_offset) && $stable(rsp_be) && $stable(rsp_data))
    else $error("rsp changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_target == hbrd_pkg::T_NONE |->
      rsp_offset == '0 && rsp_be == '0 && rsp_data == '0 && !rsp_refresh)
    else $error("ignored access carries routing data");

  a_refresh_bios: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_refresh |-> rsp_target == hbrd_pkg::T_BIOS)
    else $error("latch refresh outside a permitted BIOS read");

  a_open_bus: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_target == hbrd_pkg::T_OPEN |-> rsp_offset == '0 && rsp_data == '0)
    else $error("open-bus result with offset or data");

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind handheld_bus_region_decoder hbrd_checker u_hbrd_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_target  (rsp.target),
  .rsp_offset  (rsp.region_offset),
  .rsp_be      (rsp.byte_enable),
  .rsp_data    (rsp.lane_data),
  .rsp_refresh (rsp.refresh_bios_latch)
);
